@@ hdl/srkx_pkg.sv @@
// Shared types and constants for the shift register keystream XOR block.
`default_nettype none

package srkx_pkg;

   localparam int DATA_W        = 32;
   localparam int SEL_W         = 4;
   localparam int OP_W          = 2;
   localparam int WORDS_DEFAULT = 16;

   // Feedback taps inside word i: bits i, i + FB_TAP_B and i + FB_TAP_C, mod the word width.
   localparam int FB_TAP_B = 3;
   localparam int FB_TAP_C = 11;

   // Keystream taps relative to the pointer p: p, p + KS_TAP_B, p + WORDS/2 and
   // p + WORDS/2 + KS_TAP_D.
   localparam int KS_TAP_B = 3;
   localparam int KS_TAP_D = 5;

   typedef enum logic [OP_W-1:0] {
      OP_CRYPT     = 2'd0,
      OP_LOAD_WORD = 2'd1,
      OP_LOAD_PTR  = 2'd2
   } op_type;

   typedef struct packed {
      logic              shift_en;
      logic              load_en;
      logic [SEL_W-1:0]  load_sel;
      logic [DATA_W-1:0] load_word;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/srkx_cell.sv @@
// One word cell of the shift register chain.
`default_nettype none

module srkx_cell
   import srkx_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic              shift_in,
   input  logic              ks_sel,
   output logic              msb_out,
   output logic              fb_bit,
   output logic [DATA_W-1:0] ks_word
);

   localparam int BIT_A = IDX % DATA_W;
   localparam int BIT_B = (IDX + FB_TAP_B) % DATA_W;
   localparam int BIT_C = (IDX + FB_TAP_C) % DATA_W;
   localparam logic [SEL_W:0] IDX_S = (SEL_W+1)'(IDX);

   logic [DATA_W-1:0] word_ff;
   logic [DATA_W-1:0] word_in;
   logic              load_hit;

   assign load_hit = ctrl.load_en && ({1'b0, ctrl.load_sel} == IDX_S);

   always_comb begin
      priority if (load_hit) begin
         word_in = ctrl.load_word;
      end else if (ctrl.shift_en) begin
         word_in = {word_ff[DATA_W-2:0], shift_in};
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign msb_out = word_ff[DATA_W-1];
   assign fb_bit  = word_ff[BIT_A] ^ word_ff[BIT_B] ^ word_ff[BIT_C];
   assign ks_word = ks_sel ? word_ff : '0;

endmodule

`default_nettype wire

@@ hdl/srkx_ptr_mod.sv @@
// Reduces a loaded 32-bit pointer value modulo the register word count.
`default_nettype none

module srkx_ptr_mod
   import srkx_pkg::*;
#(
   parameter int WORDS = WORDS_DEFAULT
) (
   input  logic [DATA_W-1:0]        value,
   output logic [$clog2(WORDS)-1:0] ptr
);

   localparam int PTR_W  = $clog2(WORDS);
   localparam int SCALE1 = (1 << 8)  % WORDS;
   localparam int SCALE2 = (1 << 16) % WORDS;
   localparam int SCALE3 = (1 << 24) % WORDS;

   typedef logic [PTR_W-1:0] mod_tbl_type [256];

   // Entry v holds (v * scale) mod WORDS; each byte of the value is reduced
   // by its own table and the small sum is reduced once more.
   function automatic mod_tbl_type build_tbl(input int scale);
      mod_tbl_type t;
      for (int v = 0; v < 256; v++) begin
         t[v] = PTR_W'((v * scale) % WORDS);
      end
      return t;
   endfunction

   localparam mod_tbl_type TBL0 = build_tbl(1);
   localparam mod_tbl_type TBL1 = build_tbl(SCALE1);
   localparam mod_tbl_type TBL2 = build_tbl(SCALE2);
   localparam mod_tbl_type TBL3 = build_tbl(SCALE3);

   logic [7:0] part_sum;

   always_comb begin
      part_sum = 8'(TBL0[value[7:0]])   + 8'(TBL1[value[15:8]])
               + 8'(TBL2[value[23:16]]) + 8'(TBL3[value[31:24]]);
      ptr      = TBL0[part_sum];
   end

endmodule

`default_nettype wire

@@ hdl/shift_register_keystream_xor.sv @@
// Top level of the shift register keystream XOR block.
//
// This block encrypts or decrypts one 32-bit word per transaction by XORing it
// with a keystream word drawn from a register of WORDS 32-bit words (512 bits
// at the default of 16) and a word pointer. A crypt transaction (operation 0)
// steps the register: a feedback bit is formed from three bits of each word
// except the last, the whole register shifts left by one bit with the
// feedback entering the low bit of the last word, and the pointer advances.
// The result is the data word XOR the four words at p, p+3, p+WORDS/2 and
// p+WORDS/2+5 of the stepped register. Operation 1 loads the word chosen by
// word_select and operation 2 loads the pointer (data modulo WORDS); loads
// and operation 3 give no result, and the end_of_block flag of a crypt
// transaction travels with its result. The register is a row of word cells,
// each shifting its top bit into its neighbor every step. The block takes one
// transaction per cycle on both channels; after acceptance a crypt result
// passes one register stage for the step and one output register for the
// keystream XOR. Input is held off only while a finished result waits in the
// output register and a second one waits behind it. Reset clears the register
// words and the pointer.
`default_nettype none

module shift_register_keystream_xor
   import srkx_pkg::*;
#(
   parameter int WORDS = WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [SEL_W-1:0]  req_word_select,
   input  logic [DATA_W-1:0] req_data_word,
   input  logic              req_end_of_block,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_crypt_word,
   output logic              rsp_end_of_block_out
);

   localparam int PTR_W = $clog2(WORDS);
   localparam logic [PTR_W:0]   WORDS_X  = (PTR_W+1)'(WORDS);
   localparam logic [PTR_W:0]   OFF_B    = (PTR_W+1)'(KS_TAP_B);
   localparam logic [PTR_W:0]   OFF_C    = (PTR_W+1)'(WORDS / 2);
   localparam logic [PTR_W:0]   OFF_D    = (PTR_W+1)'(WORDS / 2 + KS_TAP_D);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WORDS - 1);

   // Adds a tap offset to the pointer and wraps it back into the word range.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W:0]   off);
      logic [PTR_W:0] s;
      s = {1'b0, p} + off;
      if (s >= WORDS_X) begin
         s = s - WORDS_X;
      end
      return s[PTR_W-1:0];
   endfunction

   logic                    req_accept;
   logic                    pend_move;
   cell_ctrl_type           ctrl;

   logic [PTR_W-1:0]        ptr_ff;
   logic [PTR_W-1:0]        ptr_in;
   logic [PTR_W-1:0]        ptr_loaded;
   logic [PTR_W-1:0]        ptr_next;

   logic                    pend_valid_ff;
   logic                    pend_valid_in;
   logic [DATA_W-1:0]       pend_data_ff;
   logic                    pend_eob_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [DATA_W-1:0]       rsp_word_ff;
   logic                    rsp_eob_ff;

   logic [WORDS-1:0]        msb_vec;
   logic [WORDS-1:0]        fb_vec;
   logic [WORDS-1:0]        ks_sel_vec;
   logic [DATA_W-1:0]       ks_words [WORDS];
   logic                    feedback;
   logic [DATA_W-1:0]       keystream;
   logic [PTR_W-1:0]        tap_b;
   logic [PTR_W-1:0]        tap_c;
   logic [PTR_W-1:0]        tap_d;

   // A pending crypt transaction reads the register in the cycle it moves to
   // the output register, so nothing new may touch the register before then.
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !pend_valid_ff || pend_move;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      ctrl.shift_en  = req_accept && (req_operation == OP_CRYPT);
      ctrl.load_en   = req_accept && (req_operation == OP_LOAD_WORD);
      ctrl.load_sel  = req_word_select;
      ctrl.load_word = req_data_word;
   end

   // The cell chain: each cell takes the top bit of the next one, and the
   // last cell takes the feedback bit.
   for (genvar g = 0; g < WORDS; g++) begin : g_cell
      logic shift_in;

      if (g == WORDS - 1) begin : g_last
         assign shift_in = feedback;
      end else begin : g_mid
         assign shift_in = msb_vec[g+1];
      end

      assign ks_sel_vec[g] = (ptr_ff == PTR_W'(g)) ^ (tap_b == PTR_W'(g))
                           ^ (tap_c == PTR_W'(g)) ^ (tap_d == PTR_W'(g));

      srkx_cell #(
         .IDX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .shift_in (shift_in),
         .ks_sel   (ks_sel_vec[g]),
         .msb_out  (msb_vec[g]),
         .fb_bit   (fb_vec[g]),
         .ks_word  (ks_words[g])
      );
   end

   // The last word takes no part in the feedback.
   assign feedback = ^fb_vec[WORDS-2:0];

   // Pointer handling.
   srkx_ptr_mod #(
      .WORDS (WORDS)
   ) u_ptr_mod (
      .value (req_data_word),
      .ptr   (ptr_loaded)
   );

   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);

   always_comb begin
      ptr_in = ptr_ff;
      if (req_accept) begin
         unique case (req_operation)
            OP_CRYPT:    ptr_in = ptr_next;
            OP_LOAD_PTR: ptr_in = ptr_loaded;
            default:     ptr_in = ptr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // Keystream taps of the already stepped register and pointer.
   assign tap_b = wrap_add(ptr_ff, OFF_B);
   assign tap_c = wrap_add(ptr_ff, OFF_C);
   assign tap_d = wrap_add(ptr_ff, OFF_D);

   always_comb begin
      keystream = '0;
      for (int i = 0; i < WORDS; i++) begin
         keystream = keystream ^ ks_words[i];
      end
   end

   // Pending stage: a crypt transaction whose register step has been done.
   always_comb begin
      pend_valid_in = pend_valid_ff && !pend_move;
      if (req_accept && (req_operation == OP_CRYPT)) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_data_ff <= req_data_word;
         pend_eob_ff  <= req_end_of_block;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_word_ff <= pend_data_ff ^ keystream;
         rsp_eob_ff  <= pend_eob_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_crypt_word       = rsp_word_ff;
   assign rsp_end_of_block_out = rsp_eob_ff;

endmodule

`default_nettype wire
